>>> src/lcmg_pkg.sv
// Shared types and constants for the load cell converter median gate.
`default_nettype none
package lcmg_pkg;
    localparam int OUT_BITS    = 24;
    localparam int LIMIT_BITS  = 24;
    localparam logic [LIMIT_BITS-1:0] SPREAD_RESET = 24'd100000;

    localparam logic CFG_FILTER_ENABLE = 1'b0;
    localparam logic CFG_SPREAD_LIMIT  = 1'b1;

    typedef logic [1:0] state_t;
    localparam state_t ST_IDLE = 2'd0;
    localparam state_t ST_OLD  = 2'd1;
    localparam state_t ST_SORT = 2'd2;
    localparam state_t ST_FIN  = 2'd3;
endpackage
`default_nettype wire

>>> src/lcmg_ring.sv
// Circular sample window memory with per-entry valid bits and slot pointer.
`default_nettype none
module lcmg_ring #(
    parameter int W  = 17,
    parameter int DW = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd,
    input  wire logic                 wr,
    input  wire logic signed [DW-1:0] wdata,
    output logic signed [DW-1:0]      rdata
);
    localparam int AW = $clog2(W);
    localparam logic [AW-1:0] LAST = AW'(W - 1);

    logic signed [DW-1:0] mem [W];
    logic [W-1:0]         vld_reg;
    logic [AW-1:0]        slot_reg;
    logic signed [DW-1:0] rdq_reg;
    logic                 rdv_reg;

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            rdq_reg <= mem[slot_reg];
        end
        if (wr)
        begin
            mem[slot_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            slot_reg <= '0;
            rdv_reg  <= 1'b0;
        end
        else
        begin
            if (rd)
            begin
                rdv_reg <= vld_reg[slot_reg];
            end
            if (wr)
            begin
                vld_reg[slot_reg] <= 1'b1;
                slot_reg <= (slot_reg == LAST) ? '0 : AW'(slot_reg + 1'b1);
            end
        end
    end

    assign rdata = rdv_reg ? rdq_reg : '0;
endmodule
`default_nettype wire

>>> src/lcmg_sort.sv
// Sorted window copy: one sweep drops the oldest sample and merges in the new one.
`default_nettype none
module lcmg_sort #(
    parameter int W  = 17,
    parameter int DW = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] old_val,
    input  wire logic signed [DW-1:0] new_val,
    output logic                      done,
    output logic signed [DW-1:0]      min_val,
    output logic signed [DW-1:0]      med_val,
    output logic signed [DW-1:0]      max_val
);
    localparam int AW = $clog2(W);
    localparam logic [AW-1:0] LAST = AW'(W - 1);
    localparam logic [AW-1:0] MID  = AW'(W / 2);

    logic signed [DW-1:0] mem [W];
    logic [W-1:0]         vld_reg;
    logic signed [DW-1:0] rdq_reg;
    logic                 rdv_reg;
    logic [AW-1:0]        k_reg;
    logic [AW-1:0]        w_reg;
    logic signed [DW-1:0] c_reg;
    logic signed [DW-1:0] old_reg;
    logic                 rm_reg;
    logic                 busy_reg;
    logic                 last_reg;
    logic                 done_reg;
    logic signed [DW-1:0] mn_reg;
    logic signed [DW-1:0] md_reg;
    logic signed [DW-1:0] mx_reg;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic signed [DW-1:0] e;
    logic                 skip;
    logic                 em_en;
    logic signed [DW-1:0] em_val;
    logic signed [DW-1:0] c_next;

    always_comb
    begin
        e       = rdv_reg ? rdq_reg : '0;
        skip    = busy_reg && !rm_reg && (e == old_reg);
        rd_en   = start || (busy_reg && (k_reg != LAST));
        rd_addr = start ? '0 : AW'(k_reg + 1'b1);
        em_en   = 1'b0;
        em_val  = c_reg;
        c_next  = c_reg;
        if (last_reg)
        begin
            em_en = 1'b1;
        end
        else if (busy_reg && !skip)
        begin
            em_en  = 1'b1;
            em_val = (e < c_reg) ? e : c_reg;
            c_next = (e < c_reg) ? c_reg : e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdq_reg <= mem[rd_addr];
        end
        if (em_en)
        begin
            mem[w_reg] <= em_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rdv_reg  <= 1'b0;
            k_reg    <= '0;
            w_reg    <= '0;
            rm_reg   <= 1'b0;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (rd_en)
            begin
                rdv_reg <= vld_reg[rd_addr];
            end
            if (em_en)
            begin
                vld_reg[w_reg] <= 1'b1;
                w_reg <= AW'(w_reg + 1'b1);
            end
            if (start)
            begin
                k_reg    <= '0;
                w_reg    <= '0;
                rm_reg   <= 1'b0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (skip)
                begin
                    rm_reg <= 1'b1;
                end
                if (k_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    last_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= AW'(k_reg + 1'b1);
                end
            end
            else if (last_reg)
            begin
                last_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            old_reg <= old_val;
            c_reg   <= new_val;
        end
        else
        begin
            c_reg <= c_next;
        end
        if (em_en && w_reg == '0)
        begin
            mn_reg <= em_val;
        end
        if (em_en && w_reg == MID)
        begin
            md_reg <= em_val;
        end
        if (em_en && w_reg == LAST)
        begin
            mx_reg <= em_val;
        end
    end

    assign done    = done_reg;
    assign min_val = mn_reg;
    assign med_val = md_reg;
    assign max_val = mx_reg;
endmodule
`default_nettype wire

>>> src/load_cell_adc_median_gate.sv
// Load cell converter median gate: code check, sign conversion, median window filter.
//
// One input item (code) yields one result item (code_valid, sample, is_negative,
// filtered). Both channels use valid/ready; config is a plain write port
// (cfg_we, cfg_index, cfg_data) that the user must write only while the block
// is idle; the block itself does not enforce this. An item is taken only while
// the block is idle, one item at a time. A rejected code or a code with filtering
// off goes from accept straight to the final state and the output register. A
// filtered code passes one window memory read, one sweep over the sorted memory
// that drops the oldest sample and merges the new one at one entry per cycle,
// and the gate decision. The next item is accepted once the block is idle again.
// The result waits in an output register while the receiver stalls; the next
// item may be accepted then, and its result waits until the register frees.
// Reset clears the window, the sorted copy (through valid bits), the held
// filtered value and the registers (filtering off, spread limit 100000).
`default_nettype none
module load_cell_adc_median_gate #(
    parameter int WINDOW    = 17,
    parameter int CODE_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [CODE_BITS-1:0]   code,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        code_valid,
    output logic signed [23:0]          sample,
    output logic                        is_negative,
    output logic signed [23:0]          filtered,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [23:0]            cfg_data
);
    localparam int DW = CODE_BITS;
    localparam int CW = (DW + 1 > lcmg_pkg::LIMIT_BITS) ? DW + 1 : lcmg_pkg::LIMIT_BITS;

    lcmg_pkg::state_t state_reg;
    logic                 fen_reg;
    logic [lcmg_pkg::LIMIT_BITS-1:0] limit_reg;
    logic signed [DW-1:0] smp_reg;
    logic                 cv_reg;
    logic                 neg_reg;
    logic signed [DW-1:0] held_reg;
    logic signed [DW-1:0] held_next;
    logic                 ov_reg;
    logic                 ocv_reg;
    logic signed [23:0]   osmp_reg;
    logic                 oneg_reg;
    logic signed [23:0]   ofil_reg;

    logic                 accept;
    logic                 cv_in;
    logic                 ring_rd;
    logic                 ring_wr;
    logic signed [DW-1:0] ring_old;
    logic                 sort_start;
    logic                 sort_done;
    logic signed [DW-1:0] mn;
    logic signed [DW-1:0] md;
    logic signed [DW-1:0] mx;
    logic [DW:0]          spread;
    logic                 out_free;

    assign in_ready   = (state_reg == lcmg_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign cv_in      = (code != '0) && (code != '1);
    assign ring_rd    = accept && cv_in && fen_reg;
    assign ring_wr    = (state_reg == lcmg_pkg::ST_OLD);
    assign sort_start = ring_wr;
    assign out_free   = !ov_reg || out_ready;
    assign spread     = {mx[DW-1], mx} - {mn[DW-1], mn};
    assign held_next  = (CW'(spread) <= CW'(limit_reg)) ? md : smp_reg;

    lcmg_ring #(.W(WINDOW), .DW(DW)) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (ring_rd),
        .wr    (ring_wr),
        .wdata (smp_reg),
        .rdata (ring_old)
    );

    lcmg_sort #(.W(WINDOW), .DW(DW)) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .old_val (ring_old),
        .new_val (smp_reg),
        .done    (sort_done),
        .min_val (mn),
        .med_val (md),
        .max_val (mx)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= cv_in ? $signed(code) : '0;
            cv_reg  <= cv_in;
            neg_reg <= cv_in && code[CODE_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcmg_pkg::ST_IDLE;
            fen_reg   <= 1'b0;
            limit_reg <= lcmg_pkg::SPREAD_RESET;
            held_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lcmg_pkg::CFG_FILTER_ENABLE: fen_reg   <= cfg_data[0];
                    lcmg_pkg::CFG_SPREAD_LIMIT:  limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ov_reg && out_ready && state_reg != lcmg_pkg::ST_FIN)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                lcmg_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ring_rd ? lcmg_pkg::ST_OLD : lcmg_pkg::ST_FIN;
                    end
                end
                lcmg_pkg::ST_OLD:
                begin
                    state_reg <= lcmg_pkg::ST_SORT;
                end
                lcmg_pkg::ST_SORT:
                begin
                    if (sort_done)
                    begin
                        held_reg  <= held_next;
                        state_reg <= lcmg_pkg::ST_FIN;
                    end
                end
                lcmg_pkg::ST_FIN:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= lcmg_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= lcmg_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lcmg_pkg::ST_FIN && out_free)
        begin
            ocv_reg  <= cv_reg;
            osmp_reg <= 24'(smp_reg);
            oneg_reg <= neg_reg;
            ofil_reg <= 24'(held_reg);
        end
    end

    assign out_valid   = ov_reg;
    assign code_valid  = ocv_reg;
    assign sample      = osmp_reg;
    assign is_negative = oneg_reg;
    assign filtered    = ofil_reg;
endmodule
`default_nettype wire

>>> src/lcmg_check.sv
// Port-level checks for the median gate, bound to the top level.
`default_nettype none
module lcmg_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               code_valid,
    input wire logic signed [23:0] sample,
    input wire logic               is_negative,
    input wire logic signed [23:0] filtered
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(sample))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !code_valid |-> sample == 24'sd0 && !is_negative)
        else $error("rejected code with nonzero sample");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");
endmodule

bind load_cell_adc_median_gate lcmg_check u_lcmg_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_valid  (code_valid),
    .sample      (sample),
    .is_negative (is_negative),
    .filtered    (filtered)
);
`default_nettype wire
